/* sv/lrp_pkg.sv */
package lrp_pkg;

    localparam int MAX_FRAMES_DEF = 8;
    localparam int PAGE_BITS_DEF  = 16;
    localparam int CFG_W          = 4;
    localparam int CNT_W          = 32;

    localparam logic [CFG_W-1:0] FRAMES_RESET = 4'd3;
    localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};

    // Control that every cell of the stack sees in the same cycle.
    typedef struct packed {
        logic load;
        logic hit;
    } cell_ctl_t;

endpackage

/* sv/lrp_cell.sv */
module lrp_cell
    import lrp_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int OCC_W     = 4,
    parameter int IDX       = 0
)
(
    input  logic                 clk,
    input  cell_ctl_t            ctl,
    input  logic [PAGE_BITS-1:0] page,
    input  logic [PAGE_BITS-1:0] nbr_entry,
    input  logic [OCC_W-1:0]     occ,
    input  logic [OCC_W-1:0]     lim,
    input  logic                 seen_in,
    input  logic [PAGE_BITS-1:0] ev_in,
    output logic [PAGE_BITS-1:0] entry,
    output logic                 seen_out,
    output logic [PAGE_BITS-1:0] ev_out
);

    logic [PAGE_BITS-1:0] entry_reg;
    logic                 occupied;
    logic                 match;
    logic                 bottom;
    logic                 shift;

    assign occupied = OCC_W'(IDX) < occ;
    assign bottom   = OCC_W'(IDX + 1) == occ;
    assign match    = occupied && (entry_reg == page);
    assign seen_out = seen_in | match;

    // The bottom resident page travels down the chain as the eviction candidate.
    assign ev_out   = ev_in | (bottom ? entry_reg : '0);

    // On a hit every cell above the matching one moves down one place; on a
    // miss every cell down to the limit does.
    assign shift    = ctl.hit ? !seen_in : (OCC_W'(IDX) <= lim);

    always_ff @(posedge clk)
    begin
        if (ctl.load && shift)
        begin
            entry_reg <= nbr_entry;
        end
    end

    assign entry = entry_reg;

endmodule

/* sv/lru_page_replacement.sv */
// The result word of a reference is registered at the clock edge that accepts the reference.
// One reference per cycle unless the result is stalled; a new word is taken as the result is taken.
// The whole stack is updated at once by the row of cells comparing in parallel.
// Reset: asynchronous, active low; the stack is empty, both totals are zero and
// frames_reg is 3. No clearing pass is needed.
module lru_page_replacement
    import lrp_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PAGE_BITS-1:0] page,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic                 evicted_valid,
    output logic [PAGE_BITS-1:0] evicted_page,
    output logic [CNT_W-1:0]     hit_total,
    output logic [CNT_W-1:0]     fault_total
);

    localparam int OCC_W = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

    logic [CFG_W-1:0]     frames_reg;
    logic [OCC_W-1:0]     occ_reg;
    logic [OCC_W-1:0]     occ_next;
    logic [CNT_W-1:0]     hit_cnt_reg;
    logic [CNT_W-1:0]     hit_cnt_next;
    logic [CNT_W-1:0]     fault_cnt_reg;
    logic [CNT_W-1:0]     fault_cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 hit_reg;
    logic                 ev_valid_reg;
    logic [PAGE_BITS-1:0] ev_page_reg;

    logic [CMP_W-1:0]     cfg_ext;
    logic [CMP_W-1:0]     max_ext;
    logic [CMP_W-1:0]     frames;
    logic                 evict;
    logic [OCC_W-1:0]     lim;
    logic                 load;
    cell_ctl_t            ctl;

    logic [PAGE_BITS-1:0] entry [MAX_FRAMES];
    logic [PAGE_BITS-1:0] nbr   [MAX_FRAMES];
    logic                 seen  [MAX_FRAMES+1];
    logic [PAGE_BITS-1:0] ev    [MAX_FRAMES+1];

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign load      = in_valid && in_ready;

    assign cfg_ext = CMP_W'(frames_reg);
    assign max_ext = CMP_W'(MAX_FRAMES);
    assign frames  = (cfg_ext == '0) ? CMP_W'(1) :
                     ((cfg_ext > max_ext) ? max_ext : cfg_ext);

    assign evict = CMP_W'(occ_reg) >= frames;
    assign lim   = evict ? (occ_reg - OCC_W'(1)) : occ_reg;

    assign seen[0] = 1'b0;
    assign ev[0]   = '0;
    assign ctl.load = load;
    assign ctl.hit  = seen[MAX_FRAMES];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_FRAMES; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_top
                assign nbr[gi] = page;
            end
            else
            begin : g_rest
                assign nbr[gi] = entry[gi-1];
            end

            lrp_cell #(
                .PAGE_BITS (PAGE_BITS),
                .OCC_W     (OCC_W),
                .IDX       (gi)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .page      (page),
                .nbr_entry (nbr[gi]),
                .occ       (occ_reg),
                .lim       (lim),
                .seen_in   (seen[gi]),
                .ev_in     (ev[gi]),
                .entry     (entry[gi]),
                .seen_out  (seen[gi+1]),
                .ev_out    (ev[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        occ_next       = occ_reg;
        hit_cnt_next   = hit_cnt_reg;
        fault_cnt_next = fault_cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            if (ctl.hit)
            begin
                if (hit_cnt_reg != CNT_MAX)
                begin
                    hit_cnt_next = hit_cnt_reg + CNT_W'(1);
                end
            end
            else
            begin
                if (!evict)
                begin
                    occ_next = occ_reg + OCC_W'(1);
                end
                if (fault_cnt_reg != CNT_MAX)
                begin
                    fault_cnt_next = fault_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg    <= FRAMES_RESET;
            occ_reg       <= '0;
            hit_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                frames_reg <= cfg_data;
            end
            occ_reg       <= occ_next;
            hit_cnt_reg   <= hit_cnt_next;
            fault_cnt_reg <= fault_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hit_reg      <= ctl.hit;
            ev_valid_reg <= !ctl.hit && evict;
            ev_page_reg  <= (!ctl.hit && evict) ? ev[MAX_FRAMES] : '0;
        end
    end

    // The totals only move when a word is accepted, which needs the output to be free or being taken.
    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign hit_total     = hit_cnt_reg;
    assign fault_total   = fault_cnt_reg;

endmodule

/* sv/lrp_checker.sv */
module lrp_checker
    import lrp_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 hit,
    input logic                 evicted_valid,
    input logic [PAGE_BITS-1:0] evicted_page,
    input logic [CNT_W-1:0]     hit_total,
    input logic [CNT_W-1:0]     fault_total
);

    // A hit never evicts anything.
    a_evict_only_on_fault: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && evicted_valid |-> !hit
    ) else $error("eviction reported on a hit");

    a_evict_page_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !evicted_valid |-> evicted_page == '0
    ) else $error("evicted page not zero without eviction");

    a_hit_counted: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> hit_total != '0
    ) else $error("hit word with zero hit total");

    a_fault_counted: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> fault_total != '0
    ) else $error("fault word with zero fault total");

    a_stall_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit_total) && $stable(fault_total)
    ) else $error("result word changed while stalled");

endmodule

bind lru_page_replacement lrp_checker #(.PAGE_BITS(PAGE_BITS)) u_lrp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .hit_total     (hit_total),
    .fault_total   (fault_total)
);
